[rtl/core/spq_pkg.sv]
// Package for the stable priority task queue.
// Holds the operation codes and the word and control types shared by all files.
// Has no dependencies.
`default_nettype none

package spq_pkg;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam int unsigned HANDLE_W   = 8;
  localparam int unsigned ARGUMENT_W = 32;
  localparam int unsigned PRIO_IN_W  = 4;
  localparam int unsigned COUNT_W    = 5;

  typedef struct packed {
    logic                  func;
    logic [HANDLE_W-1:0]   task_handle;
    logic [ARGUMENT_W-1:0] task_argument;
    logic [PRIO_IN_W-1:0]  task_priority;
  } req_word_t;

  typedef struct packed {
    logic                  pop_valid;
    logic [HANDLE_W-1:0]   out_handle;
    logic [ARGUMENT_W-1:0] out_argument;
    logic [COUNT_W-1:0]    entry_count;
    logic                  push_dropped;
  } rsp_word_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   handle;
    logic [ARGUMENT_W-1:0] argument;
  } slot_data_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/spq_if.sv]
// Valid/ready channel interfaces for the request and response words.
// Depends on spq_pkg for the word types.
`default_nettype none

interface spq_req_if
  import spq_pkg::*;
  ;
  logic      valid;
  logic      ready;
  req_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
  ;
  logic      valid;
  logic      ready;
  rsp_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[rtl/core/spq_cell.sv]
// One slot of the shift-register queue: holds a priority and its task data.
// Loads the new entry, its left neighbor or its right neighbor. Uses spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIORITY_BITS = 4
) (
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic                     occupied,
  input  wire logic [PRIORITY_BITS-1:0] new_prio,
  input  wire slot_data_t               new_data,
  input  wire logic                     left_lt,
  input  wire logic [PRIORITY_BITS-1:0] left_prio,
  input  wire slot_data_t               left_data,
  input  wire logic [PRIORITY_BITS-1:0] right_prio,
  input  wire slot_data_t               right_data,
  output logic                          lt,
  output logic [PRIORITY_BITS-1:0]      prio,
  output slot_data_t                    data
);

  logic [PRIORITY_BITS-1:0] prio_next;
  slot_data_t               data_next;

  // An empty slot counts as lower, so a push meeting no lower entry lands last.
  assign lt = !occupied || (prio < new_prio);

  always_comb begin
    prio_next = prio;
    data_next = data;
    if (ctrl.pop) begin
      prio_next = right_prio;
      data_next = right_data;
    end else if (ctrl.push && lt) begin
      if (left_lt) begin
        prio_next = left_prio;
        data_next = left_data;
      end else begin
        prio_next = new_prio;
        data_next = new_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    data <= data_next;
  end

endmodule

`default_nettype wire

[rtl/core/stable_priority_task_queue_unit.sv]
// Stable priority task queue: a row of QUEUE_DEPTH slot cells kept sorted by
// priority, oldest first among equal priorities. Each request word is handled
// with every cell comparing against the new priority in parallel and shifting
// toward its neighbor, so a new word is taken every cycle while the response
// register is free or being drained. A pop on an empty queue returns pop_valid
// low, and a push into a full queue is dropped with push_dropped high.
// Uses spq_pkg, the channel interfaces in spq_if and the spq_cell module.
`default_nettype none

module stable_priority_task_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 4
) (
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     rsp_valid;
  rsp_word_t                rsp_word;
  rsp_word_t                rsp_word_next;
  logic                     accept;
  logic                     full;
  logic                     empty;
  cell_ctrl_t               ctrl;
  logic [PRIORITY_BITS-1:0] new_prio;
  slot_data_t               new_data;

  logic                     lt_q   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_q [QUEUE_DEPTH];
  slot_data_t               data_q [QUEUE_DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  assign new_prio          = PRIORITY_BITS'(req.word.task_priority);
  assign new_data.handle   = req.word.task_handle;
  assign new_data.argument = req.word.task_argument;

  assign ctrl.push = accept && (req.word.func == FUNC_PUSH) && !full;
  assign ctrl.pop  = accept && (req.word.func == FUNC_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     left_lt;
    logic [PRIORITY_BITS-1:0] left_prio;
    slot_data_t               left_data;
    logic [PRIORITY_BITS-1:0] right_prio;
    slot_data_t               right_data;

    if (i == 0) begin : g_head
      assign left_lt   = 1'b0;
      assign left_prio = new_prio;
      assign left_data = new_data;
    end else begin : g_body
      assign left_lt   = lt_q[i-1];
      assign left_prio = prio_q[i-1];
      assign left_data = data_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_prio = prio_q[i];
      assign right_data = data_q[i];
    end else begin : g_inner
      assign right_prio = prio_q[i+1];
      assign right_data = data_q[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CW'(i) < count),
      .new_prio  (new_prio),
      .new_data  (new_data),
      .left_lt   (left_lt),
      .left_prio (left_prio),
      .left_data (left_data),
      .right_prio(right_prio),
      .right_data(right_data),
      .lt        (lt_q[i]),
      .prio      (prio_q[i]),
      .data      (data_q[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    rsp_word_next              = '0;
    rsp_word_next.pop_valid    = ctrl.pop;
    rsp_word_next.out_handle   = ctrl.pop ? data_q[0].handle : '0;
    rsp_word_next.out_argument = ctrl.pop ? data_q[0].argument : '0;
    rsp_word_next.entry_count  = COUNT_W'(count_next);
    rsp_word_next.push_dropped = (req.word.func == FUNC_PUSH) && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_word <= rsp_word_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.word  = rsp_word;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("held count exceeds queue depth");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> count == $past(count) - CW'(1))
    else $error("pop did not remove exactly one entry");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.word.push_dropped |-> rsp.word.entry_count == COUNT_W'(QUEUE_DEPTH))
    else $error("push dropped while queue not full");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> prio_q[0] >= prio_q[1])
    else $error("head slots out of priority order");

endmodule

`default_nettype wire
